### rtl/mcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsr_pkg: shared constants and types for the feed-cycle motor controller
// sizes, register indexes, phase codes and event codes
// ----------------------------------------------------------------------------
package mcsr_pkg;

    localparam int FILTER_DEPTH = 8;
    localparam int STAMP_WIDTH  = 32;
    localparam int SLOT_W       = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int FILL_W       = $clog2(FILTER_DEPTH + 1);
    localparam int SUM_W        = 13 + $clog2(FILTER_DEPTH + 1);
    localparam int DIV_W        = 22;

    // ceil(2^23 / 31): mv * 1000 / 620 is (mv * 50) / 31
    localparam logic [18:0] MA_RECIP = 19'd270601;

    localparam logic [12:0] DEFAULT_THRESHOLD = 13'd80;
    localparam logic [12:0] STALL_MARGIN      = 13'd20;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FWD   = 2'd1,
        PH_REV   = 2'd2,
        PH_FAULT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_FAULT    = 2'd2,
        EV_TIMEOUT  = 2'd3
    } event_t;

    localparam logic [2:0] REG_LIMIT_EN  = 3'd0;
    localparam logic [2:0] REG_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_INTERVAL  = 3'd2;
    localparam logic [2:0] REG_BLANKING  = 3'd3;
    localparam logic [2:0] REG_CAL_DELAY = 3'd4;
    localparam logic [2:0] REG_PAUSE     = 3'd5;
    localparam logic [2:0] REG_NORMAL    = 3'd6;
    localparam logic [2:0] REG_STALL     = 3'd7;

    // input word fields
    typedef struct packed {
        logic        power_save;
        logic [11:0] shunt_mv;
        logic        sample_valid;
        logic        limit_level;
        logic        limit_event;
        logic        clear_fault;
        logic        start_request;
    } in_word_t;

    // request to and answer from the filter unit
    typedef struct packed {
        logic        start;
        logic [11:0] mv;
    } filt_req_t;

    typedef struct packed {
        logic        done;
        logic [12:0] mean;
    } filt_rsp_t;

endpackage

### rtl/mcsr_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsr_filter: sample conversion and running mean
// converts mv to ma with a reciprocal multiply, then sums the store one
// entry a cycle and divides by the fill count with a shift-subtract divider
// ----------------------------------------------------------------------------
module mcsr_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  mcsr_pkg::filt_req_t req,
    output mcsr_pkg::filt_rsp_t rsp
);
    import mcsr_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CONV, S_STORE, S_SUM, S_MEAN, S_DONE} st_t;

    st_t                st_reg;
    logic [12:0]        store_reg [FILTER_DEPTH];
    logic [SLOT_W-1:0]  slot_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  idx_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [17:0]        conv_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   den_reg;
    logic [4:0]         bit_reg;
    logic [12:0]        mean_reg;

    // mv * 50 times the reciprocal of 31, quotient in bits 23 and up
    logic [36:0] conv_prod;
    assign conv_prod = {19'b0, conv_reg} * {18'b0, MA_RECIP};

    // one restoring division step
    logic [DIV_W-1:0] rem_sh;
    logic             fits;
    always_comb
    begin
        rem_sh = {rem_reg[DIV_W-2:0], num_reg[bit_reg]};
        fits   = rem_sh >= den_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            slot_reg <= '0;
            fill_reg <= '0;
            mean_reg <= '0;
            for (int i = 0; i < FILTER_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        conv_reg <= {1'b0, req.mv, 5'b0} + {2'b0, req.mv, 4'b0}
                                    + {5'b0, req.mv, 1'b0};
                        st_reg   <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    quo_reg <= DIV_W'(conv_prod[36:23]);
                    st_reg  <= S_STORE;
                end
                S_MEAN:
                begin
                    rem_reg <= fits ? rem_sh - den_reg : rem_sh;
                    quo_reg <= {quo_reg[DIV_W-2:0], fits};
                    if (bit_reg == 5'd0)
                        st_reg <= S_DONE;
                    else
                        bit_reg <= bit_reg - 5'd1;
                end
                S_STORE:
                begin
                    store_reg[slot_reg] <= quo_reg[12:0];
                    slot_reg <= (slot_reg == SLOT_W'(FILTER_DEPTH - 1)) ? '0
                                : slot_reg + SLOT_W'(1);
                    if (fill_reg < FILL_W'(FILTER_DEPTH))
                        fill_reg <= fill_reg + FILL_W'(1);
                    idx_reg <= '0;
                    sum_reg <= '0;
                    st_reg  <= S_SUM;
                end
                S_SUM:
                begin
                    if (idx_reg == fill_reg)
                    begin
                        num_reg <= DIV_W'(sum_reg);
                        den_reg <= DIV_W'(fill_reg);
                        rem_reg <= '0;
                        quo_reg <= '0;
                        bit_reg <= 5'(DIV_W - 1);
                        st_reg  <= S_MEAN;
                    end
                    else
                    begin
                        sum_reg <= sum_reg + SUM_W'(store_reg[idx_reg[SLOT_W-1:0]]);
                        idx_reg <= idx_reg + FILL_W'(1);
                    end
                end
                S_DONE:
                begin
                    mean_reg <= quo_reg[12:0];
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.done = (st_reg == S_DONE);
    assign rsp.mean = quo_reg[12:0];

endmodule

### rtl/motor_cycle_stall_reverse_ctrl_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_cycle_stall_reverse_ctrl_unit: feed-cycle motor controller top level
// sequence: each tick word passes T_FILT, T_PROC and T_OUT; with a current sample it
//   waits in T_FILT for the filter unit (one reciprocal multiply, a summing pass over the
//   filled store entries and a 22-step division by the fill count)
// flow: the unit takes no tick word while busy or while its result word waits
// reset: asynchronous, active low; configuration and state registers return to their defaults
// ----------------------------------------------------------------------------
module motor_cycle_stall_reverse_ctrl_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_request, clear_fault, limit_event, limit_level, sample_valid,
    // shunt_mv[11:0], power_save, zero fill
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // drive_a, drive_b, cycle_state[1:0], motor_running, avg_current[12:0],
    // threshold_ma[12:0], event_code[1:0], start_accepted, zero fill
    output logic [39:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mcsr_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_FILT, T_PROC, T_OUT} tst_t;
    localparam logic [STAMP_WIDTH-1:0] ONE = STAMP_WIDTH'(1);

    tst_t              tst_reg;
    in_word_t          in_reg;
    logic              lim_en_reg;
    logic [15:0]       timeout_reg, blank_ms_reg, cal_reg, pause_reg;
    logic [9:0]        intv_reg;
    logic [12:0]       normal_reg, stall_reg;
    logic [STAMP_WIDTH-1:0] now_reg, start_st_reg, blank_st_reg, check_st_reg, pend_st_reg;
    phase_t            phase_reg;
    logic              running_reg, dir_rev_reg, calib_reg, latched_reg, blanked_reg;
    logic              check_v_reg, lim_pend_reg, pend_rev_reg, pend_fwd_reg;
    logic [15:0]       elapsed_reg;
    logic [12:0]       thr_reg, mean_reg;
    logic [1:0]        evcnt_reg, confirm_reg;
    event_t            ev_reg;
    logic              acc_reg;
    logic [39:0]       out_reg;
    logic              out_v_reg;
    logic              filt_busy_reg;
    filt_req_t         freq;
    filt_rsp_t         frsp;

    mcsr_filter u_filter (.clk(clk), .rst_n(rst_n), .req(freq), .rsp(frsp));

    // configuration only between tick words, and it wins over a new tick word
    assign cfg_ready = (tst_reg == T_IDLE) && !out_v_reg;
    assign s_tready  = (tst_reg == T_IDLE) && !out_v_reg && !cfg_valid;
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_reg;
    assign freq.start = (tst_reg == T_FILT) && in_reg.sample_valid && !frsp.done
                        && !filt_busy_reg;
    assign freq.mv    = in_reg.shunt_mv;

    // cycle process on the registered tick state
    logic [STAMP_WIDTH-1:0] pn;
    phase_t ph;
    logic run, dr, cal, lat, blk, chk, lp, prv, pfw;
    logic [15:0] el;
    logic [12:0] thr;
    logic [1:0] ec, cc;
    logic [STAMP_WIDTH-1:0] sst, bst, cst, pst;
    event_t ev;
    logic acc, skip;
    logic [13:0] thr_m;

    always_comb
    begin
        pn = now_reg; ph = phase_reg; run = running_reg; dr = dir_rev_reg;
        cal = calib_reg; lat = latched_reg; blk = blanked_reg; chk = check_v_reg;
        lp = lim_pend_reg; prv = pend_rev_reg; pfw = pend_fwd_reg; el = elapsed_reg;
        thr = thr_reg; ec = evcnt_reg; cc = confirm_reg; sst = start_st_reg;
        bst = blank_st_reg; cst = check_st_reg; pst = pend_st_reg;
        ev = EV_NONE; acc = 1'b0; skip = 1'b0; thr_m = '0;

        if (run)
        begin
            el = el + 16'd1;
            if (el >= timeout_reg)
            begin
                ph = PH_IDLE; run = 1'b0; el = '0;
                ec = '0; lat = 0; blk = 0; bst = '0; cst = '0; chk = 0; cal = 0;
                thr = DEFAULT_THRESHOLD; prv = 0; pfw = 0; ev = EV_TIMEOUT;
            end
        end
        if (in_reg.clear_fault && ph == PH_FAULT)
        begin
            ph = PH_IDLE;
            ec = '0; lat = 0; blk = 0; bst = '0; cst = '0; chk = 0; cal = 0;
            thr = DEFAULT_THRESHOLD;
        end
        if (in_reg.start_request && !in_reg.power_save)
        begin
            if (ph == PH_FAULT || ph == PH_IDLE)
            begin
                ph = PH_FWD;
                ec = '0; lat = 0; blk = 0; bst = '0; cst = '0; chk = 0;
                thr = DEFAULT_THRESHOLD;
                dr = 0; el = '0; run = 1; sst = pn; cal = 0; acc = 1;
            end
        end
        if (in_reg.limit_event && lim_en_reg && !in_reg.limit_level &&
            (pn - sst) >= STAMP_WIDTH'(cal_reg))
        begin
            run = 0; el = '0; lp = 1;
        end

        if (lp)
        begin
            lp = 0;
            if (ph == PH_FWD)
            begin
                ph = PH_IDLE;
                ec = '0; lat = 0; blk = 0; bst = '0; cst = '0; chk = 0; cal = 0;
                thr = DEFAULT_THRESHOLD; ev = EV_COMPLETE;
            end
            else if (ph == PH_REV)
            begin
                ph = PH_FWD; blk = 1; bst = pn; run = 0; el = '0; pfw = 1; pst = pn;
            end
        end
        if (ph == PH_IDLE || ph == PH_FAULT)
            skip = 1;
        if (!skip)
        begin
            if (prv && (pn - pst) >= STAMP_WIDTH'(pause_reg))
            begin
                prv = 0; dr = 1; el = '0; run = 1; sst = pn; cal = 0;
                blk = 1; bst = pn; lat = 1;
            end
            if (pfw && (pn - pst) >= STAMP_WIDTH'(pause_reg))
            begin
                pfw = 0; dr = 0; el = '0; run = 1; sst = pn; cal = 0;
                blk = 1; bst = pn;
            end
            if (chk && (pn - cst) < STAMP_WIDTH'(intv_reg))
                skip = 1;
        end
        if (!skip)
        begin
            cst = pn; chk = 1;
            if (blk)
            begin
                if ((pn - bst) >= STAMP_WIDTH'(blank_ms_reg))
                begin
                    blk = 0; lat = 0;
                end
                else
                    skip = 1;
            end
        end
        if (!skip)
        begin
            if (run && !cal && (pn - sst) >= STAMP_WIDTH'(cal_reg) && mean_reg != '0)
            begin
                if (mean_reg <= normal_reg)     thr = normal_reg;
                else if (mean_reg < stall_reg)  thr = mean_reg;
                else                            thr = DEFAULT_THRESHOLD;
                cal = 1;
            end
            thr_m = {1'b0, thr} + {1'b0, STALL_MARGIN};
            if ({1'b0, mean_reg} > thr_m && (pn - sst) >= STAMP_WIDTH'(cal_reg))
            begin
                cc = cc + 2'd1;
                if (cc >= 2'd2)
                begin
                    if (!lat)
                    begin
                        lat = 1;
                        ec = ec + 2'd1;
                        if (ec >= 2'd2 || ph == PH_REV)
                        begin
                            run = 0; el = '0; ph = PH_FAULT; ev = EV_FAULT;
                        end
                        else
                        begin
                            run = 0; el = '0; ph = PH_REV; prv = 1; pst = pn; lat = 1;
                        end
                    end
                    cc = '0;
                end
            end
            else if (mean_reg < thr)
            begin
                lat = 0; cc = '0;
            end
        end
    end

    // tick sequencer, state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tst_reg <= T_IDLE; out_v_reg <= 0; filt_busy_reg <= 0;
            lim_en_reg <= 1; timeout_reg <= 16'd20000; intv_reg <= 10'd20;
            blank_ms_reg <= 16'd1000; cal_reg <= 16'd1500; pause_reg <= 16'd300;
            normal_reg <= 13'd70; stall_reg <= 13'd150;
            now_reg <= '0; phase_reg <= PH_IDLE; running_reg <= 0; dir_rev_reg <= 0;
            elapsed_reg <= '0; start_st_reg <= '0; thr_reg <= DEFAULT_THRESHOLD;
            calib_reg <= 0; evcnt_reg <= '0; latched_reg <= 0; blanked_reg <= 0;
            blank_st_reg <= '0; check_st_reg <= '0; check_v_reg <= 0;
            lim_pend_reg <= 0; pend_rev_reg <= 0; pend_fwd_reg <= 0;
            pend_st_reg <= '0; confirm_reg <= '0; mean_reg <= '0;
        end
        else
        begin
            if (out_v_reg && m_tready)
                out_v_reg <= 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LIMIT_EN:
                    begin
                        lim_en_reg <= cfg_data[0];
                        if (!cfg_data[0]) lim_pend_reg <= 0;
                    end
                    REG_TIMEOUT:   timeout_reg  <= cfg_data;
                    REG_INTERVAL:  intv_reg     <= cfg_data[9:0];
                    REG_BLANKING:  blank_ms_reg <= cfg_data;
                    REG_CAL_DELAY: cal_reg      <= cfg_data;
                    REG_PAUSE:     pause_reg    <= cfg_data;
                    REG_NORMAL:    normal_reg   <= cfg_data[12:0];
                    REG_STALL:     stall_reg    <= cfg_data[12:0];
                    default: ;
                endcase
            end
            case (tst_reg)
                T_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        in_reg  <= in_word_t'(s_tdata[17:0]);
                        now_reg <= now_reg + ONE;
                        tst_reg <= T_FILT;
                    end
                end
                T_FILT:
                begin
                    if (!in_reg.sample_valid)
                        tst_reg <= T_PROC;
                    else if (frsp.done)
                    begin
                        mean_reg <= frsp.mean; filt_busy_reg <= 0; tst_reg <= T_PROC;
                    end
                    else
                        filt_busy_reg <= 1;
                end
                T_PROC:
                begin
                    phase_reg <= ph; running_reg <= run; dir_rev_reg <= dr;
                    calib_reg <= cal; latched_reg <= lat; blanked_reg <= blk;
                    check_v_reg <= chk; lim_pend_reg <= lp; pend_rev_reg <= prv;
                    pend_fwd_reg <= pfw; elapsed_reg <= el; thr_reg <= thr;
                    evcnt_reg <= ec; confirm_reg <= cc; start_st_reg <= sst;
                    blank_st_reg <= bst; check_st_reg <= cst; pend_st_reg <= pst;
                    ev_reg <= ev; acc_reg <= acc;
                    tst_reg <= T_OUT;
                end
                T_OUT:
                begin
                    out_reg <= {6'b0, acc_reg, ev_reg, thr_reg, mean_reg, running_reg,
                                phase_reg, running_reg && dir_rev_reg,
                                running_reg && !dir_rev_reg};
                    out_v_reg <= 1;
                    tst_reg   <= T_IDLE;
                end
                default: tst_reg <= T_IDLE;
            endcase
        end
    end

endmodule

### test/tb_motor_cycle_stall_reverse_ctrl_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_cycle_stall_reverse_ctrl_unit: self-checking bench for the feed-cycle controller
// drives 1 ms tick words with random gaps and output stalls, predicts every
// result word with a tick-level copy of the controller and compares fields
// ----------------------------------------------------------------------------
module tb_motor_cycle_stall_reverse_ctrl_unit;
    import mcsr_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 120;

    // one result word split into fields
    typedef struct packed {
        logic        drive_a;
        logic        drive_b;
        logic [1:0]  cycle_state;
        logic        motor_running;
        logic [12:0] avg_current;
        logic [12:0] threshold_ma;
        logic [1:0]  event_code;
        logic        start_accepted;
    } tick_result_t;

    // controller predictor plus queue of expected result words
    class feed_scoreboard;
        bit [31:0]  limit_en, timeout_ms, interval_ms, blank_ms, cal_ms, pause_len;
        bit [31:0]  normal_ma, stall_ma;
        bit [31:0]  now_ms, run_elapsed, start_stamp, stall_thr, event_count;
        bit [31:0]  blank_stamp, last_check, pend_stamp, confirm_count;
        bit [31:0]  mean_ma, fill, slot;
        bit [31:0]  store [FILTER_DEPTH];
        phase_t     phase;
        event_t     ev;
        bit         running, dir_rev, calibrated, latched, blanked, check_valid;
        bit         limit_pending, pend_rev, pend_fwd;
        tick_result_t expected_q[$];
        int         mismatches;

        function new();
            limit_en = 1; timeout_ms = 20000; interval_ms = 20; blank_ms = 1000;
            cal_ms = 1500; pause_len = 300; normal_ma = 70; stall_ma = 150;
            now_ms = 0; phase = PH_IDLE; running = 0; dir_rev = 0; run_elapsed = 0;
            start_stamp = 0; confirm_count = 0; limit_pending = 0; pend_rev = 0;
            pend_fwd = 0; pend_stamp = 0; mean_ma = 0; fill = 0; slot = 0;
            foreach (store[i]) store[i] = 0;
            clear_context();
            mismatches = 0;
        endfunction

        function bit [31:0] age(bit [31:0] stamp);
            return now_ms - stamp;
        endfunction

        function void clear_context();
            event_count = 0; latched = 0; blanked = 0; blank_stamp = 0;
            last_check = 0; check_valid = 0; calibrated = 0;
            stall_thr = DEFAULT_THRESHOLD;
        endfunction

        function void stop_motor();
            running = 0;
            run_elapsed = 0;
        endfunction

        function void start_drive(bit rev);
            dir_rev = rev; run_elapsed = 0; running = 1;
            start_stamp = now_ms; calibrated = 0;
        endfunction

        function void enter_fault();
            stop_motor();
            phase = PH_FAULT;
            ev = EV_FAULT;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_LIMIT_EN:
                begin
                    limit_en = v[0];
                    if (!v[0]) limit_pending = 0;
                end
                REG_TIMEOUT:   timeout_ms = v;
                REG_INTERVAL:  interval_ms = v[9:0];
                REG_BLANKING:  blank_ms = v;
                REG_CAL_DELAY: cal_ms = v;
                REG_PAUSE:     pause_len = v;
                REG_NORMAL:    normal_ma = v[12:0];
                REG_STALL:     stall_ma = v[12:0];
                default: ;
            endcase
        endfunction

        function void add_sample(logic [11:0] mv);
            bit [31:0] sum;
            sum = 0;
            store[slot] = (32'(mv) * 1000) / 620;
            slot = (slot + 1) % FILTER_DEPTH;
            if (fill < FILTER_DEPTH) fill++;
            for (int i = 0; i < fill; i++) sum += store[i];
            mean_ma = (sum / fill) & 32'h1FFF;
        endfunction

        function void overcurrent();
            if (phase == PH_IDLE || phase == PH_FAULT) return;
            event_count = (event_count + 1) & 3;
            if (event_count >= 2)
                enter_fault();
            else if (phase == PH_FWD)
            begin
                stop_motor();
                phase = PH_REV;
                pend_rev = 1; pend_stamp = now_ms; latched = 1;
            end
            else
                enter_fault();
        endfunction

        function void run_cycle();
            if (limit_pending)
            begin
                limit_pending = 0;
                if (phase == PH_FWD)
                begin
                    phase = PH_IDLE;
                    clear_context();
                    ev = EV_COMPLETE;
                end
                else if (phase == PH_REV)
                begin
                    phase = PH_FWD; blanked = 1; blank_stamp = now_ms;
                    stop_motor();
                    pend_fwd = 1; pend_stamp = now_ms;
                end
            end
            if (phase == PH_IDLE || phase == PH_FAULT) return;
            if (pend_rev && age(pend_stamp) >= pause_len)
            begin
                pend_rev = 0; start_drive(1);
                blanked = 1; blank_stamp = now_ms; latched = 1;
            end
            if (pend_fwd && age(pend_stamp) >= pause_len)
            begin
                pend_fwd = 0; start_drive(0);
                blanked = 1; blank_stamp = now_ms;
            end
            if (check_valid && age(last_check) < interval_ms) return;
            last_check = now_ms;
            check_valid = 1;
            if (blanked)
            begin
                if (age(blank_stamp) >= blank_ms)
                begin
                    blanked = 0; latched = 0;
                end
                else
                    return;
            end
            if (running && !calibrated && age(start_stamp) >= cal_ms && mean_ma > 0)
            begin
                if (mean_ma <= normal_ma) stall_thr = normal_ma;
                else if (mean_ma < stall_ma) stall_thr = mean_ma;
                else stall_thr = DEFAULT_THRESHOLD;
                calibrated = 1;
            end
            if (mean_ma > stall_thr + 20 && age(start_stamp) >= cal_ms)
            begin
                confirm_count = (confirm_count + 1) & 3;
                if (confirm_count >= 2)
                begin
                    if (!latched)
                    begin
                        latched = 1;
                        overcurrent();
                    end
                    confirm_count = 0;
                end
            end
            else if (mean_ma < stall_thr)
            begin
                latched = 0; confirm_count = 0;
            end
        endfunction

        // accepted tick word: advance the controller one millisecond
        function void note_tick(in_word_t w);
            tick_result_t r;
            bit accepted;
            accepted = 0;
            ev = EV_NONE;
            now_ms++;
            if (running)
            begin
                run_elapsed = (run_elapsed + 1) & 32'hFFFF;
                if (run_elapsed >= timeout_ms)
                begin
                    phase = PH_IDLE; stop_motor(); clear_context();
                    pend_rev = 0; pend_fwd = 0; ev = EV_TIMEOUT;
                end
            end
            if (w.clear_fault && phase == PH_FAULT)
            begin
                phase = PH_IDLE; clear_context();
            end
            if (w.start_request && !w.power_save)
            begin
                if (phase == PH_FAULT)
                begin
                    phase = PH_IDLE; clear_context();
                end
                if (phase == PH_IDLE)
                begin
                    clear_context(); phase = PH_FWD; start_drive(0); accepted = 1;
                end
            end
            if (w.limit_event && limit_en[0] && !w.limit_level && age(start_stamp) >= cal_ms)
            begin
                stop_motor(); limit_pending = 1;
            end
            if (w.sample_valid) add_sample(w.shunt_mv);
            run_cycle();
            r.drive_a = running && !dir_rev;
            r.drive_b = running && dir_rev;
            r.cycle_state = phase;
            r.motor_running = running;
            r.avg_current = mean_ma[12:0];
            r.threshold_ma = stall_thr[12:0];
            r.event_code = ev;
            r.start_accepted = accepted;
            expected_q.push_back(r);
        endfunction

        // accepted result word: compare with the oldest expectation
        function void check_result(logic [39:0] d);
            tick_result_t e, a;
            a.drive_a = d[0]; a.drive_b = d[1]; a.cycle_state = d[3:2];
            a.motor_running = d[4]; a.avg_current = d[17:5]; a.threshold_ma = d[30:18];
            a.event_code = d[32:31]; a.start_accepted = d[33];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", d);
                return;
            end
            e = expected_q.pop_front();
            if (a != e)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: exp a%0d b%0d st%0d run%0d f%0d thr%0d ev%0d acc%0d",
                        e.drive_a, e.drive_b, e.cycle_state, e.motor_running,
                        e.avg_current, e.threshold_ma, e.event_code, e.start_accepted);
                    $display("          got a%0d b%0d st%0d run%0d f%0d thr%0d ev%0d acc%0d",
                        a.drive_a, a.drive_b, a.cycle_state, a.motor_running,
                        a.avg_current, a.threshold_ma, a.event_code, a.start_accepted);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    feed_scoreboard sb;
    bit  no_gaps;
    bit  heavy_load;
    int  cycle_count;

    motor_cycle_stall_reverse_ctrl_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("** motor_cycle_stall_reverse_ctrl_unit: FAILED **");
                $finish;
            end
        end
    end

    // result side with random stalls
    initial
    begin
        int stall;
        stall = 0;
        m_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata);
                stall = no_gaps ? 0 : $urandom_range(0, 3);
                m_tready <= (stall == 0);
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= (stall == 0);
            end
            else
                m_tready <= 1;
        end
    end

    task automatic send_tick(in_word_t w);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, w};
        do @(posedge clk); while (!s_tready);
        sb.note_tick(w);
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_reg(idx, v);
    endtask

    task automatic load_regs(logic [15:0] lim, logic [15:0] tmo, logic [15:0] ivl,
                             logic [15:0] blk, logic [15:0] cal, logic [15:0] pau,
                             logic [15:0] nrm, logic [15:0] stl);
        wait_drained();
        write_reg(REG_LIMIT_EN, lim);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_INTERVAL, ivl);
        write_reg(REG_BLANKING, blk);
        write_reg(REG_CAL_DELAY, cal);
        write_reg(REG_PAUSE, pau);
        write_reg(REG_NORMAL, nrm);
        write_reg(REG_STALL, stl);
    endtask

    function automatic in_word_t make_tick(bit st, bit clr, bit lev, bit lvl, bit sv,
                                           logic [11:0] mv, bit ps);
        in_word_t w;
        w.start_request = st; w.clear_fault = clr; w.limit_event = lev;
        w.limit_level = lvl; w.sample_valid = sv; w.shunt_mv = mv; w.power_save = ps;
        return w;
    endfunction

    // random tick: mostly running cycles with bursts of high current
    task automatic random_ticks(int count);
        in_word_t w;
        logic [11:0] mv;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 29) == 0) heavy_load = !heavy_load;
            if ($urandom_range(0, 99) == 0) no_gaps = !no_gaps;
            case ($urandom_range(0, 9))
                0:       mv = 12'($urandom);
                1:       mv = 12'hFFF;
                default: mv = heavy_load ? 12'($urandom_range(100, 4095))
                                         : 12'($urandom_range(0, 60));
            endcase
            w = make_tick($urandom_range(0, 7) == 0,
                          (sb.phase == PH_FAULT) ? $urandom_range(0, 2) == 0
                                                 : $urandom_range(0, 19) == 0,
                          $urandom_range(0, 11) == 0, $urandom_range(0, 3) == 0,
                          $urandom_range(0, 3) != 0, mv, $urandom_range(0, 15) == 0);
            send_tick(w);
        end
    endtask

    initial
    begin
        sb = new();
        no_gaps = 0;
        heavy_load = 0;
        rst_n = 0;
        s_tvalid <= 0;
        s_tdata <= '0;
        cfg_valid <= 0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (8) @(posedge clk);
        rst_n = 1;
        @(posedge clk);

        // directed ticks at reset settings
        send_tick(make_tick(0, 0, 0, 0, 0, 12'd0, 0));
        send_tick(make_tick(0, 1, 0, 0, 1, 12'hFFF, 0));    // clear outside fault
        send_tick(make_tick(1, 0, 0, 0, 1, 12'd0, 1));      // start refused in power save
        send_tick(make_tick(0, 0, 1, 0, 1, 12'd40, 0));     // limit while idle
        send_tick(make_tick(1, 0, 0, 0, 1, 12'd4095, 0));   // start accepted
        send_tick(make_tick(1, 0, 0, 0, 1, 12'd4095, 0));   // start refused while running
        send_tick(make_tick(0, 0, 1, 1, 0, 12'd0, 0));      // limit glitch
        send_tick(make_tick(0, 0, 1, 0, 1, 12'd62, 0));     // limit before calibration delay
        send_tick(make_tick(0, 1, 1, 1, 1, 12'd4095, 1));
        for (int i = 0; i < 8; i++)
            send_tick(make_tick(0, 0, 0, 0, 1, 12'(i * 585), 0));

        // short timings so cycles, stalls and timeouts happen often
        load_regs(16'd1, 16'd80, 16'd2, 16'd4, 16'd3, 16'd2, 16'd70, 16'd150);
        random_ticks(200);

        // zero delays and floors, longest timeout
        load_regs(16'd1, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_ticks(120);

        // limits ignored, shortest timeout, largest values elsewhere
        load_regs(16'd0, 16'd1, 16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'd8191, 16'd8191);
        random_ticks(60);

        // mid range with an idle pause halfway
        load_regs(16'd1, 16'd40, 16'd1, 16'd2, 16'd2, 16'd5, 16'd100, 16'd3000);
        random_ticks(100);
        wait_drained();
        random_ticks(100);

        wait_drained();
        if (sb.mismatches == 0)
            $display("** motor_cycle_stall_reverse_ctrl_unit: PASSED **");
        else
            $display("** motor_cycle_stall_reverse_ctrl_unit: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/mcsr_pkg.sv
rtl/mcsr_filter.sv
rtl/motor_cycle_stall_reverse_ctrl_unit.sv
test/tb_motor_cycle_stall_reverse_ctrl_unit.sv
